@@ rtl/core/mfst_pkg.sv @@
// Package: constants, types and helper functions for the multilevel flow session table.
`default_nettype none
package mfst_pkg;
   localparam int LEVEL0_LOG2 = 12;
   localparam int LEVEL_COUNT = 4;
   localparam int LEVEL0_SIZE = 1 << LEVEL0_LOG2;
   localparam int TABLE_DEPTH = (LEVEL0_SIZE * 15) / 8;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int SLOT_W      = LEVEL0_LOG2;

   localparam logic [1:0] STATUS_HIT  = 2'd0;
   localparam logic [1:0] STATUS_NEW  = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   localparam logic [31:0] SEED0 = 32'd16777213;
   localparam logic [31:0] SEED1 = 32'd8388593;
   localparam logic [31:0] SEED2 = 32'd4194301;
   localparam logic [31:0] SEED3 = 32'd2097143;

   localparam logic CSR_MAX_ROUNDS = 1'b0;

   typedef struct packed {
      logic [31:0] packets;
      logic [31:0] saddr;
      logic [31:0] daddr;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [7:0]  protocol;
      logic [31:0] tx;
      logic [31:0] rx;
      logic [31:0] drop;
   } entry_type;

   localparam int ROW_W = $bits(entry_type);

   function automatic logic [31:0] level_seed(input logic [1:0] d);
      logic [31:0] s;
      unique case (d)
         2'd0: s = SEED0;
         2'd1: s = SEED1;
         2'd2: s = SEED2;
         default: s = SEED3;
      endcase
      return s;
   endfunction

   function automatic logic [IDX_W-1:0] level_base(input logic [1:0] d);
      logic [IDX_W:0] b;
      b = (IDX_W+1)'(2 * (LEVEL0_SIZE - (LEVEL0_SIZE >> d)));
      return b[IDX_W-1:0];
   endfunction

   function automatic logic [SLOT_W-1:0] level_mask(input logic [1:0] d);
      logic [SLOT_W:0] m;
      m = (SLOT_W+1)'((LEVEL0_SIZE >> d) - 1);
      return m[SLOT_W-1:0];
   endfunction
endpackage
`default_nettype wire

@@ rtl/core/multilevel_flow_session_table_top.sv @@
// Top level: flow session table sequencer, probe memory and register port.
// Usage:
//  - Input: drive req_* and pulse start while busy is low; the transaction is
//    taken at that edge. busy stays high until the result has been produced.
//  - Result: rsp_strobe is high for exactly one cycle with rsp_* valid. The
//    receiver cannot stall; the result is consumed in that cycle.
//  - Config: APB-style write of max_rounds at address 0, pready always high.
//    Writes are taken at any time, but are only meant while the block is idle.
//  - Timing: each probe is a memory read (PROBE state), then a check and write
//    back (CHECK state) through the single table memory. A transaction is
//    resolved at probe k (k = 1 .. 4*(max_rounds+1)); rsp_strobe is registered
//    from the CHECK state of that probe. busy is low in the strobe cycle, so the
//    next start is taken at its end; no new transaction is taken while one is busy.
//  - Reset: synchronous, active high. After reset a clearing pass writes every
//    one of the 7680 table rows, one per cycle, holding busy high throughout;
//    max_rounds resets to 3.
`default_nettype none
module multilevel_flow_session_table_top import mfst_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_saddr,
   input  wire logic [31:0] req_daddr,
   input  wire logic [15:0] req_sport,
   input  wire logic [15:0] req_dport,
   input  wire logic [7:0]  req_protocol,
   input  wire logic [15:0] req_tx_add,
   input  wire logic [15:0] req_rx_add,
   input  wire logic [15:0] req_drop_add,
   output logic             rsp_strobe,
   output logic      [1:0]  rsp_status,
   output logic      [1:0]  rsp_level,
   output logic      [11:0] rsp_slot,
   output logic      [4:0]  rsp_round,
   output logic      [31:0] rsp_packets,
   output logic      [31:0] rsp_tx_total,
   output logic      [31:0] rsp_rx_total,
   output logic      [31:0] rsp_drop_total,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready
);
   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_PROBE = 2'd2;
   localparam logic [1:0] ST_CHECK = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [4:0]       max_rounds_ff;
   logic [1:0]       level_ff, level_in;
   logic [4:0]       round_ff, round_in;

   logic [31:0] sa_ff, da_ff;
   logic [15:0] sp_ff, dp_ff, tx_ff, rx_ff, dr_ff;
   logic [7:0]  pr_ff;

   logic             rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [1:0]       rsp_level_ff, rsp_level_in;
   logic [11:0]      rsp_slot_ff, rsp_slot_in;
   logic [4:0]       rsp_round_ff, rsp_round_in;
   entry_type        rsp_entry_ff, rsp_entry_in;

   logic [SLOT_W-1:0] slot;
   logic [IDX_W-1:0]  index;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   entry_type         wr_row, rd_row;
   logic [ROW_W-1:0]  rd_bits;
   logic              addr_ok, port_ok, match, free_slot, accept;

   mfst_hash u_hash (
      .saddr    (sa_ff),
      .daddr    (da_ff),
      .sport    (sp_ff),
      .dport    (dp_ff),
      .protocol (pr_ff),
      .level    (level_ff),
      .round    (round_ff),
      .slot     (slot),
      .index    (index)
   );

   mfst_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_row),
      .rd_addr (index),
      .rd_data (rd_bits)
   );

   assign rd_row = entry_type'(rd_bits);
   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      addr_ok = (sa_ff == rd_row.saddr && da_ff == rd_row.daddr) ||
                (sa_ff == rd_row.daddr && da_ff == rd_row.saddr);
      port_ok = (sp_ff == rd_row.sport && dp_ff == rd_row.dport) ||
                (sp_ff == rd_row.dport && dp_ff == rd_row.sport);
      free_slot = (rd_row.packets == 32'd0);
      match     = addr_ok && port_ok && (pr_ff == rd_row.protocol);

      state_in      = state_ff;
      clr_in        = clr_ff;
      level_in      = level_ff;
      round_in      = round_ff;
      wr_en         = 1'b0;
      wr_addr       = index;
      wr_row        = rd_row;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_round_in  = rsp_round_ff;
      rsp_entry_in  = rsp_entry_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_row  = '0;
            clr_in  = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               level_in = 2'd0;
               round_in = 5'd0;
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            state_in = ST_CHECK;
         end
         default: begin
            priority if (free_slot || match) begin
               if (free_slot) begin
                  wr_row.packets  = 32'd1;
                  wr_row.saddr    = sa_ff;
                  wr_row.daddr    = da_ff;
                  wr_row.sport    = sp_ff;
                  wr_row.dport    = dp_ff;
                  wr_row.protocol = pr_ff;
                  wr_row.tx       = 32'(tx_ff);
                  wr_row.rx       = 32'(rx_ff);
                  wr_row.drop     = 32'(dr_ff);
                  rsp_status_in   = STATUS_NEW;
               end else begin
                  wr_row.packets = rd_row.packets + 32'd1;
                  wr_row.tx      = rd_row.tx + 32'(tx_ff);
                  wr_row.rx      = rd_row.rx + 32'(rx_ff);
                  wr_row.drop    = rd_row.drop + 32'(dr_ff);
                  rsp_status_in  = STATUS_HIT;
               end
               wr_en         = 1'b1;
               rsp_strobe_in = 1'b1;
               rsp_level_in  = level_ff;
               rsp_slot_in   = 12'(slot);
               rsp_round_in  = round_ff;
               rsp_entry_in  = wr_row;
               state_in      = ST_IDLE;
            end else if (level_ff != 2'd3) begin
               level_in = level_ff + 2'd1;
               state_in = ST_PROBE;
            end else if (round_ff != max_rounds_ff) begin
               level_in = 2'd0;
               round_in = round_ff + 5'd1;
               state_in = ST_PROBE;
            end else begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = STATUS_FULL;
               rsp_level_in  = 2'd0;
               rsp_slot_in   = 12'd0;
               rsp_round_in  = 5'd0;
               rsp_entry_in  = '0;
               state_in      = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         max_rounds_ff <= 5'd3;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (psel && penable && pwrite && paddr[2] == CSR_MAX_ROUNDS) begin
            max_rounds_ff <= pwdata[4:0];
         end
      end
      level_ff      <= level_in;
      round_ff      <= round_in;
      rsp_status_ff <= rsp_status_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_round_ff  <= rsp_round_in;
      rsp_entry_ff  <= rsp_entry_in;
      if (accept) begin
         sa_ff <= req_saddr;
         da_ff <= req_daddr;
         sp_ff <= req_sport;
         dp_ff <= req_dport;
         pr_ff <= req_protocol;
         tx_ff <= req_tx_add;
         rx_ff <= req_rx_add;
         dr_ff <= req_drop_add;
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_level      = rsp_level_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_round      = rsp_round_ff;
   assign rsp_packets    = rsp_entry_ff.packets;
   assign rsp_tx_total   = rsp_entry_ff.tx;
   assign rsp_rx_total   = rsp_entry_ff.rx;
   assign rsp_drop_total = rsp_entry_ff.drop;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_MAX_ROUNDS) ? 32'(max_rounds_ff) : 32'd0;
endmodule
`default_nettype wire

@@ rtl/core/mfst_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module mfst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

@@ rtl/core/mfst_hash.sv @@
// Probe hash: maps a tuple, level and retry round to a slot and a table index.
`default_nettype none
module mfst_hash import mfst_pkg::*; (
   input  wire logic [31:0]       saddr,
   input  wire logic [31:0]       daddr,
   input  wire logic [15:0]       sport,
   input  wire logic [15:0]       dport,
   input  wire logic [7:0]        protocol,
   input  wire logic [1:0]        level,
   input  wire logic [4:0]        round,
   output logic      [SLOT_W-1:0] slot,
   output logic      [IDX_W-1:0]  index
);
   logic [7:0]  amt;
   logic        zero_all;
   logic [31:0] t1, t2, t3, t4, h;

   always_comb begin
      amt      = protocol - 8'(level) - 8'd1;
      zero_all = (protocol <= 8'(level)) || (amt >= 8'd32);
      t1 = 32'(saddr[31:16]) + 32'(daddr[15:0]);
      t2 = 32'(daddr[31:16]);
      t3 = 32'(sport[15:8]) + 32'(dport[7:0]);
      t4 = 32'(dport[15:8]);
      if (zero_all) begin
         t1 = '0;
         t2 = '0;
         t3 = '0;
         t4 = '0;
      end else begin
         t1 = t1 >> amt[4:0];
         t2 = t2 >> amt[4:0];
         t3 = t3 >> amt[4:0];
         t4 = t4 >> amt[4:0];
      end
      h = (level_seed(level) >> round) ^ t1 ^ 32'(saddr[15:0]) ^ t2
          ^ t3 ^ 32'(sport[7:0]) ^ t4;
      slot  = h[SLOT_W-1:0] & level_mask(level);
      index = level_base(level) + IDX_W'(slot);
   end
endmodule
`default_nettype wire
